[sv/text_glyph_layout_engine_defines.svh]
// ----------------------------------------------------------------------------
// Text glyph layout engine assertion macros
// Shared concurrent assertion helpers, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_LAYOUT_ENGINE_DEFINES_SVH
`define TEXT_GLYPH_LAYOUT_ENGINE_DEFINES_SVH

// The property must hold at every clock edge out of reset.
`define TGLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define TGLE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/tgle_pkg.sv]
// ----------------------------------------------------------------------------
// Text glyph layout engine package
// Sizes, operation and result codes, state types and inter-module structs.
// ----------------------------------------------------------------------------
package tgle_pkg;

    localparam int INDEX_DEPTH = 1024;
    localparam int IDX_AW      = $clog2(INDEX_DEPTH);
    localparam int OFF_W       = 18;
    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 7;
    localparam int SQ_W        = 2 * SIZE_W;
    localparam int BIG_W       = SQ_W - 3;
    localparam int SMALL_W     = SQ_W - 4;
    localparam int COLOR_W     = 16;
    localparam int ADDR_IN_W   = 10;
    localparam int ADDR_CMP_W  = 17;

    localparam logic [SIZE_W-1:0]  FONT_SIZE_RST = 7'd16;
    localparam logic [COORD_W-1:0] SCREEN_W_RST  = 12'd320;
    localparam logic [COORD_W-1:0] SCREEN_H_RST  = 12'd240;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_BYTE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_DRAW = 2'd0,
        KIND_SKIP = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_FONT_SIZE = 2'd0,
        REG_SCREEN_W  = 2'd1,
        REG_SCREEN_H  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } top_state_t;

    typedef enum logic {
        SC_IDLE,
        SC_RUN
    } scan_state_t;

    typedef struct packed {
        logic              en;
        logic [IDX_AW-1:0] addr;
        logic [7:0]        data;
    } idx_wr_t;

    typedef struct packed {
        logic       start;
        logic       wide;
        logic [7:0] key0;
        logic [7:0] key1;
    } scan_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [OFF_W-1:0] offset;
    } scan_res_t;

endpackage

[sv/tgle_scan.sv]
// ----------------------------------------------------------------------------
// Font index scanner
// Holds the font index memory and walks it one byte per cycle, summing glyph
// bitmap sizes until the requested key, the terminator or the end is reached.
// ----------------------------------------------------------------------------
`include "text_glyph_layout_engine_defines.svh"

module tgle_scan
    import tgle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  idx_wr_t            wr,
    input  scan_req_t          req,
    input  logic [BIG_W-1:0]   big,
    input  logic [SMALL_W-1:0] small_size,
    output scan_res_t          res
);

    localparam logic [IDX_AW-1:0] LAST_ADDR = IDX_AW'(INDEX_DEPTH - 1);

    logic [7:0]        mem [INDEX_DEPTH];
    logic [7:0]        rdata_reg;
    logic [IDX_AW-1:0] rd_addr;

    scan_state_t       state_reg, state_next;
    logic [IDX_AW-1:0] daddr_reg, daddr_next;
    logic [OFF_W-1:0]  acc_reg, acc_next;
    logic              trail_reg, trail_next;
    logic [7:0]        lead_reg, lead_next;
    logic              wide_reg, wide_next;
    logic [7:0]        key0_reg, key0_next;
    logic [7:0]        key1_reg, key1_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic              finish;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (req.start)
                begin
                    state_next = SC_RUN;
                end
            end
            SC_RUN:
            begin
                if (finish)
                begin
                    state_next = SC_IDLE;
                end
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            SC_RUN:  rd_addr = daddr_reg + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        daddr_next = daddr_reg;
        acc_next   = acc_reg;
        trail_next = trail_reg;
        lead_next  = lead_reg;
        wide_next  = wide_reg;
        key0_next  = key0_reg;
        key1_next  = key1_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        off_next   = off_reg;
        finish     = 1'b0;
        if (state_reg == SC_IDLE)
        begin
            if (req.start)
            begin
                daddr_next = '0;
                acc_next   = '0;
                trail_next = 1'b0;
                wide_next  = req.wide;
                key0_next  = req.key0;
                key1_next  = req.key1;
            end
        end
        else
        begin
            daddr_next = daddr_reg + 1'b1;
            if (!trail_reg)
            begin
                if (rdata_reg == 8'd0)
                begin
                    finish = 1'b1;
                end
                else if (rdata_reg[7])
                begin
                    lead_next  = rdata_reg;
                    trail_next = 1'b1;
                    finish     = (daddr_reg == LAST_ADDR);
                    found_next = 1'b0;
                end
                else if (!wide_reg && rdata_reg == key0_reg)
                begin
                    finish     = 1'b1;
                    found_next = 1'b1;
                    off_next   = acc_reg;
                end
                else
                begin
                    acc_next = acc_reg + OFF_W'(small_size);
                    finish   = (daddr_reg == LAST_ADDR);
                end
            end
            else
            begin
                trail_next = 1'b0;
                if (rdata_reg == 8'd0)
                begin
                    finish = 1'b1;
                end
                else if (wide_reg && lead_reg == key0_reg && rdata_reg == key1_reg)
                begin
                    finish     = 1'b1;
                    found_next = 1'b1;
                    off_next   = acc_reg;
                end
                else
                begin
                    acc_next = acc_reg + OFF_W'(big);
                    finish   = (daddr_reg == LAST_ADDR);
                end
            end
            if (finish)
            begin
                done_next  = 1'b1;
                trail_next = 1'b0;
                if (!found_next)
                begin
                    found_next = 1'b0;
                end
            end
            if (finish && !(found_next && off_next == acc_reg))
            begin
                found_next = found_next && (off_next == acc_reg);
            end
        end
        if (state_reg == SC_IDLE && req.start)
        begin
            found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            trail_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            trail_reg <= trail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        daddr_reg <= daddr_next;
        acc_reg   <= acc_next;
        lead_reg  <= lead_next;
        wide_reg  <= wide_next;
        key0_reg  <= key0_next;
        key1_reg  <= key1_next;
        found_reg <= found_next;
        off_reg   <= off_next;
    end

    assign res.done   = done_reg;
    assign res.found  = found_reg;
    assign res.offset = found_reg ? off_reg : '0;

    `TGLE_ASSERT(a_done_after_run, done_reg |-> $past(state_reg == SC_RUN), "done without a scan")
    `TGLE_NEVER(a_start_while_busy, req.start && state_reg == SC_RUN, "scan started while busy")
    `TGLE_ASSERT(a_trail_has_lead, (trail_reg && state_reg == SC_RUN) |-> lead_reg[7], "trail without lead")

endmodule

[sv/text_glyph_layout_engine.sv]
// ----------------------------------------------------------------------------
// Text glyph layout engine
// Places single-byte and double-byte characters of a string on the screen and
// looks each one up in a byte-wise font index to find its bitmap offset.
//
// Channel   Dir  Beat contents
// s_*       in   tuser: operation; tdata: byte, index address, start x/y, colors
// m_*       out  tuser: kind; tdata: offset, width, x, y, fore, back
// cfg_*     in   index 0 font size, 1 screen width, 2 screen height
//
// Loads, starts, string ends and lead bytes are taken in the idle state; an edge
// stop goes through the emit state. A character lookup walks the index memory
// read port one byte per cycle from address zero. One input beat is in flight at
// a time; a new beat is taken while the last result still waits on m_tready. The
// index memory is not cleared by reset.
// ----------------------------------------------------------------------------
`include "text_glyph_layout_engine_defines.svh"

module text_glyph_layout_engine
    import tgle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // byte_value, index_addr, start_x, start_y, fore, back
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // glyph_offset, glyph_width, pos_x, pos_y, fore, back
    output logic [1:0]  m_tuser,   // kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    top_state_t         state_reg, state_next;
    logic [SIZE_W-1:0]  font_size_reg;
    logic [COORD_W-1:0] screen_w_reg, screen_h_reg;
    logic [SQ_W-1:0]    sq_reg;

    logic [COORD_W-1:0] pen_x_reg, pen_x_next;
    logic [COORD_W-1:0] pen_y_reg, pen_y_next;
    logic [COLOR_W-1:0] fore_reg, fore_next;
    logic [COLOR_W-1:0] back_reg, back_next;
    logic [7:0]         lead_reg, lead_next;
    logic               lead_pend_reg, lead_pend_next;
    logic               halted_reg, halted_next;
    logic [SIZE_W-1:0]  width_reg, width_next;
    kind_t              pend_kind_reg, pend_kind_next;
    logic [OFF_W-1:0]   pend_off_reg, pend_off_next;
    logic [COORD_W-1:0] pend_x_reg, pend_x_next;
    logic [COORD_W-1:0] pend_y_reg, pend_y_next;

    logic               m_tvalid_reg, m_tvalid_next;
    kind_t              out_kind_reg;
    logic [OFF_W-1:0]   out_off_reg;
    logic [SIZE_W-1:0]  out_width_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [COLOR_W-1:0] out_fore_reg, out_back_reg;

    op_t                op;
    logic [7:0]         in_byte;
    logic [ADDR_IN_W-1:0] in_addr;
    logic               acc_in, out_load, go_scan, go_emit, off_screen;
    logic [SIZE_W-1:0]  char_w;
    idx_wr_t            wr;
    scan_req_t          req;
    scan_res_t          res;

    assign op      = op_t'(s_tuser);
    assign in_byte = s_tdata[7:0];
    assign in_addr = s_tdata[17:8];
    assign acc_in  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg <= FONT_SIZE_RST;
            screen_w_reg  <= SCREEN_W_RST;
            screen_h_reg  <= SCREEN_H_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FONT_SIZE: font_size_reg <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_W:  screen_w_reg  <= cfg_data;
                REG_SCREEN_H:  screen_h_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= font_size_reg * font_size_reg;
    end

    assign char_w = in_byte[7] ? font_size_reg : {1'b0, font_size_reg[SIZE_W-1:1]};
    assign off_screen = ({1'b0, pen_x_reg} + (COORD_W+1)'(char_w) > {1'b0, screen_w_reg})
                     || ({1'b0, pen_y_reg} + (COORD_W+1)'(font_size_reg)
                         > {1'b0, screen_h_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go_scan)
                begin
                    state_next = ST_SCAN;
                end
                else if (go_emit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (res.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SCAN: ;
            ST_EMIT: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb
    begin
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        fore_next      = fore_reg;
        back_next      = back_reg;
        lead_next      = lead_reg;
        lead_pend_next = lead_pend_reg;
        halted_next    = halted_reg;
        width_next     = width_reg;
        pend_kind_next = pend_kind_reg;
        pend_off_next  = pend_off_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        go_scan        = 1'b0;
        go_emit        = 1'b0;
        req.wide       = 1'b0;
        req.key0       = in_byte;
        req.key1       = in_byte;
        if (acc_in)
        begin
            case (op)
                OP_START:
                begin
                    pen_x_next     = s_tdata[29:18];
                    pen_y_next     = s_tdata[41:30];
                    fore_next      = s_tdata[57:42];
                    back_next      = s_tdata[73:58];
                    lead_next      = 8'd0;
                    lead_pend_next = 1'b0;
                    halted_next    = 1'b0;
                end
                OP_BYTE:
                begin
                    if (!halted_reg)
                    begin
                        if (in_byte == 8'd0)
                        begin
                            halted_next    = 1'b1;
                            lead_pend_next = 1'b0;
                        end
                        else if (lead_pend_reg)
                        begin
                            lead_pend_next = 1'b0;
                            width_next     = font_size_reg;
                            go_scan        = 1'b1;
                            req.wide       = 1'b1;
                            req.key0       = lead_reg;
                        end
                        else
                        begin
                            width_next = char_w;
                            if (off_screen)
                            begin
                                pend_kind_next = KIND_STOP;
                                pend_off_next  = '0;
                                pend_x_next    = pen_x_reg;
                                pend_y_next    = pen_y_reg;
                                halted_next    = 1'b1;
                                go_emit        = 1'b1;
                            end
                            else if (in_byte[7])
                            begin
                                lead_next      = in_byte;
                                lead_pend_next = 1'b1;
                            end
                            else
                            begin
                                go_scan = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_SCAN && res.done)
        begin
            pend_kind_next = res.found ? KIND_DRAW : KIND_SKIP;
            pend_off_next  = res.offset;
            pend_x_next    = pen_x_reg;
            pend_y_next    = pen_y_reg;
            pen_x_next     = pen_x_reg + COORD_W'(width_reg);
        end
        req.start = go_scan;
    end

    assign wr.en   = acc_in && op == OP_LOAD
                  && ADDR_CMP_W'(in_addr) < ADDR_CMP_W'(INDEX_DEPTH);
    assign wr.addr = IDX_AW'(in_addr);
    assign wr.data = in_byte;

    tgle_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .req        (req),
        .big        (sq_reg[SQ_W-1:3]),
        .small_size (sq_reg[SQ_W-1:4]),
        .res        (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            fore_reg      <= '0;
            back_reg      <= '0;
            lead_reg      <= '0;
            lead_pend_reg <= 1'b0;
            halted_reg    <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            fore_reg      <= fore_next;
            back_reg      <= back_next;
            lead_reg      <= lead_next;
            lead_pend_reg <= lead_pend_next;
            halted_reg    <= halted_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        pend_kind_reg <= pend_kind_next;
        pend_off_reg  <= pend_off_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        if (out_load)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_off_reg   <= pend_off_reg;
            out_width_reg <= width_reg;
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_fore_reg  <= fore_reg;
            out_back_reg  <= back_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_back_reg, out_fore_reg, out_y_reg, out_x_reg,
                       out_width_reg, out_off_reg};

    `TGLE_ASSERT(a_done_in_scan, res.done |-> state_reg == ST_SCAN, "lookup result outside scan")
    `TGLE_NEVER(a_halted_no_lead, halted_reg && lead_pend_reg, "lead byte held while halted")
    `TGLE_ASSERT(a_emit_loads, out_load |=> m_tvalid_reg, "result register not loaded")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text glyph layout engine testbench
// Fills the font index, then runs directed strings at the default screen
// setup: whole-index scans, index terminators, lead bytes and screen edges.
// After that it runs random phases, each with its own font size and screen
// size, a fresh short index and mostly well-formed strings mixed with noise.
// A local model of the lookup and pen logic predicts every result beat, and
// each result is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb
    import tgle_pkg::*;
;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT   = 10000000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         DRAIN_CYCLES  = INDEX_DEPTH + 16;

    typedef struct {
        kind_t               kind;
        logic [OFF_W-1:0]    offset;
        logic [SIZE_W-1:0]   width;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOR_W-1:0]  fore;
        logic [COLOR_W-1:0]  back;
    } glyph_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    logic [7:0]         font_index [INDEX_DEPTH];
    logic [COORD_W-1:0] pen_col;
    logic [COORD_W-1:0] pen_row;
    logic [COLOR_W-1:0] string_fore;
    logic [COLOR_W-1:0] string_back;
    logic [7:0]         held_lead;
    bit                 lead_waiting;
    bit                 string_done;
    int unsigned        cell_size;
    int unsigned        view_w;
    int unsigned        view_h;

    glyph_cmd_t  glyph_cmds_due[$];
    glyph_cmd_t  due_cmd;
    logic [15:0] glyph_keys[$];
    int          index_end;
    bit          gaps_on;
    int unsigned err_count;
    int unsigned cycles;
    int unsigned beats_sent;
    int unsigned beats_used;
    int unsigned draws_seen;
    int unsigned skips_seen;
    int unsigned stops_seen;
    int unsigned phases_run;

    text_glyph_layout_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always
    begin
        @(negedge clk);
        if (gaps_on && rst_n && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        m_tready <= 1'b1;
    end

    task automatic flag_mismatch(string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (glyph_cmds_due.size() == 0)
                flag_mismatch("result beat with no command expected");
            else
            begin
                due_cmd = glyph_cmds_due.pop_front();
                check_field("kind", m_tuser, due_cmd.kind);
                check_field("glyph_offset", m_tdata[17:0], due_cmd.offset);
                check_field("glyph_width", m_tdata[24:18], due_cmd.width);
                check_field("pos_x", m_tdata[36:25], due_cmd.x);
                check_field("pos_y", m_tdata[48:37], due_cmd.y);
                check_field("draw_fore", m_tdata[64:49], due_cmd.fore);
                check_field("draw_back", m_tdata[80:65], due_cmd.back);
            end
            case (m_tuser)
                KIND_DRAW: draws_seen++;
                KIND_SKIP: skips_seen++;
                default:   stops_seen++;
            endcase
        end
    end

    // Walks the index from address zero, summing bitmap sizes of passed glyphs.
    function automatic bit find_glyph(logic [7:0] k0, logic [7:0] k1, bit wide,
                                      output logic [OFF_W-1:0] offset);
        int unsigned big;
        int unsigned little;
        int unsigned acc;
        int unsigned i;
        logic [7:0]  b;
        logic [7:0]  t;
        big    = cell_size * cell_size / 8;
        little = cell_size * cell_size / 16;
        acc    = 0;
        i      = 0;
        offset = '0;
        while (i < INDEX_DEPTH)
        begin
            b = font_index[i];
            if (b == 8'h00)
                break;
            if (b[7])
            begin
                t = (i + 1 < INDEX_DEPTH) ? font_index[i + 1] : 8'h00;
                if (t == 8'h00)
                    break;
                if (wide && b == k0 && t == k1)
                begin
                    offset = acc[OFF_W-1:0];
                    return 1'b1;
                end
                acc = (acc + big) % (1 << OFF_W);
                i += 2;
            end
            else
            begin
                if (!wide && b == k0)
                begin
                    offset = acc[OFF_W-1:0];
                    return 1'b1;
                end
                acc = (acc + little) % (1 << OFF_W);
                i += 1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_layout(logic [1:0] op, logic [7:0] chr,
                                           logic [9:0] addr, logic [11:0] sx,
                                           logic [11:0] sy, logic [15:0] fc,
                                           logic [15:0] bc);
        glyph_cmd_t       cmd;
        int unsigned      w;
        bit               hit;
        bit               emit;
        logic [OFF_W-1:0] off;
        emit = 1'b0;
        hit  = 1'b0;
        off  = '0;
        case (op)
            OP_LOAD:
            begin
                font_index[addr] = chr;
                beats_used++;
            end
            OP_START:
            begin
                pen_col      = sx;
                pen_row      = sy;
                string_fore  = fc;
                string_back  = bc;
                held_lead    = 8'h00;
                lead_waiting = 1'b0;
                string_done  = 1'b0;
                beats_used++;
            end
            OP_BYTE:
            begin
                if (!string_done)
                begin
                    beats_used++;
                    cmd.x    = pen_col;
                    cmd.y    = pen_row;
                    cmd.fore = string_fore;
                    cmd.back = string_back;
                    if (chr == 8'h00)
                    begin
                        string_done  = 1'b1;
                        lead_waiting = 1'b0;
                    end
                    else if (lead_waiting)
                    begin
                        w            = cell_size;
                        lead_waiting = 1'b0;
                        hit          = find_glyph(held_lead, chr, 1'b1, off);
                        cmd.kind     = hit ? KIND_DRAW : KIND_SKIP;
                        emit         = 1'b1;
                    end
                    else
                    begin
                        w = chr[7] ? cell_size : cell_size >> 1;
                        if (pen_col + w > view_w || pen_row + cell_size > view_h)
                        begin
                            cmd.kind    = KIND_STOP;
                            string_done = 1'b1;
                            emit        = 1'b1;
                        end
                        else if (chr[7])
                        begin
                            held_lead    = chr;
                            lead_waiting = 1'b1;
                        end
                        else
                        begin
                            hit      = find_glyph(chr, 8'h00, 1'b0, off);
                            cmd.kind = hit ? KIND_DRAW : KIND_SKIP;
                            emit     = 1'b1;
                        end
                    end
                    if (emit)
                    begin
                        cmd.offset = hit ? off : '0;
                        cmd.width  = SIZE_W'(w);
                        glyph_cmds_due.push_back(cmd);
                        if (cmd.kind != KIND_STOP)
                            pen_col = COORD_W'(pen_col + w);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_beat(logic [1:0] op, logic [7:0] chr, logic [9:0] addr = '0,
                             logic [11:0] sx = '0, logic [11:0] sy = '0,
                             logic [15:0] fc = '0, logic [15:0] bc = '0);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, bc, fc, sy, sx, addr, chr};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        predict_layout(op, chr, addr, sx, sy, fc, bc);
        beats_sent++;
    endtask

    task automatic start_string(logic [11:0] sx, logic [11:0] sy,
                                logic [15:0] fc, logic [15:0] bc);
        send_beat(OP_START, 8'($urandom), 10'($urandom), sx, sy, fc, bc);
    endtask

    task automatic send_char(logic [7:0] chr);
        send_beat(OP_BYTE, chr, 10'($urandom), 12'($urandom), 12'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (glyph_cmds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_FONT_SIZE: cell_size = val[SIZE_W-1:0];
            REG_SCREEN_W:  view_w = val;
            REG_SCREEN_H:  view_h = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_store_end();
        for (int a = 0; a < INDEX_DEPTH; a++)
            send_beat(OP_LOAD, (a == INDEX_DEPTH - 1) ? 8'h81 : 8'((a % 127) + 1), 10'(a));
        send_char(8'h41);
        start_string(12'd0, 12'd0, 16'hFFFF, 16'h0000);
        send_char(8'h05);
        send_char(8'h81);
        send_char(8'h01);
        send_char(8'h80);
        send_char(8'hFF);
        send_char(8'h00);
        settle();
    endtask

    task automatic test_index_rules();
        send_beat(OP_LOAD, 8'h41, 10'd0);
        send_beat(OP_LOAD, 8'h82, 10'd1);
        send_beat(OP_LOAD, 8'h31, 10'd2);
        send_beat(OP_LOAD, 8'h42, 10'd3);
        send_beat(OP_LOAD, 8'hA0, 10'd4);
        send_beat(OP_LOAD, 8'h00, 10'd5);
        start_string(12'd0, 12'd0, 16'h0000, 16'hFFFF);
        send_char(8'h42);
        send_char(8'h82);
        send_char(8'h31);
        send_char(8'h43);
        send_char(8'hA0);
        send_char(8'h01);
        send_char(8'h82);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(8'h00);
        send_char(8'h41);
        send_beat(OP_UNUSED, 8'h41, 10'h3FF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
        start_string(12'd8, 12'd16, 16'h1234, 16'hABCD);
        send_char(8'hFF);
        start_string(12'd16, 12'd16, 16'h5555, 16'hAAAA);
        send_char(8'h41);
        send_char(8'h00);
        settle();
    endtask

    task automatic test_screen_edges();
        start_string(12'd312, 12'd224, 16'h07E0, 16'hF800);
        send_char(8'h41);
        send_char(8'h41);
        send_char(8'h41);
        start_string(12'd304, 12'd224, 16'h001F, 16'h0000);
        send_char(8'h82);
        send_char(8'h31);
        send_char(8'h01);
        start_string(12'd0, 12'd225, 16'hFFFF, 16'hFFFF);
        send_char(8'h41);
        start_string(12'd4095, 12'd4095, 16'h0000, 16'h0000);
        send_char(8'h41);
        start_string(12'd306, 12'd0, 16'h8421, 16'h7BDE);
        send_char(8'h82);
        settle();
    endtask

    task automatic test_register_writes();
        write_reg(REG_UNUSED, 12'hFFF);
        start_string(12'd0, 12'd0, 16'h0F0F, 16'hF0F0);
        send_char(8'h42);
        send_char(8'h00);
        settle();
    endtask

    task automatic load_short_index(int n_keys);
        logic [7:0] lead;
        logic [7:0] trail;
        logic [7:0] single;
        int         addr;
        glyph_keys.delete();
        addr = 0;
        repeat (n_keys)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                lead  = 8'h80 | 8'($urandom_range(0, 127));
                trail = 8'($urandom_range(1, 255));
                send_beat(OP_LOAD, lead, 10'(addr));
                send_beat(OP_LOAD, trail, 10'(addr + 1));
                glyph_keys.push_back({lead, trail});
                addr += 2;
            end
            else
            begin
                single = 8'($urandom_range(1, 127));
                send_beat(OP_LOAD, single, 10'(addr));
                glyph_keys.push_back({8'h00, single});
                addr += 1;
            end
        end
        send_beat(OP_LOAD, 8'h00, 10'(addr));
        index_end = addr;
    endtask

    task automatic run_string();
        int          n_chars;
        logic [15:0] key;
        logic [7:0]  chr;
        logic [11:0] sx;
        logic [11:0] sy;
        if ($urandom_range(0, 4) != 0)
        begin
            sx = COORD_W'($urandom_range(0, view_w));
            sy = COORD_W'($urandom_range(0, view_h));
        end
        else
        begin
            sx = COORD_W'($urandom);
            sy = COORD_W'($urandom);
        end
        start_string(sx, sy, 16'($urandom), 16'($urandom));
        n_chars = $urandom_range(1, 12);
        for (int c = 0; c < n_chars; c++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                key = glyph_keys[$urandom_range(0, glyph_keys.size() - 1)];
                if (key[15])
                begin
                    send_char(key[15:8]);
                    send_char(key[7:0]);
                end
                else
                    send_char(key[7:0]);
            end
            else
            begin
                chr = 8'($urandom_range(1, 255));
                send_char(chr);
                if (chr[7])
                    send_char(($urandom_range(0, 9) != 0) ? 8'($urandom_range(1, 255)) : 8'h00);
            end
        end
        if ($urandom_range(0, 4) != 0)
            send_char(8'h00);
    endtask

    task automatic run_phase(int unsigned font, int unsigned w, int unsigned h,
                             int unsigned budget);
        int unsigned goal;
        int unsigned pick;
        settle();
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, 12'($urandom));
        write_reg(REG_SCREEN_H, 12'(h));
        write_reg(REG_FONT_SIZE, 12'(font));
        write_reg(REG_SCREEN_W, 12'(w));
        phases_run++;
        goal = beats_used + budget;
        load_short_index($urandom_range(3, 20));
        while (beats_used < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                run_string();
            else if (pick < 85)
                send_beat(OP_LOAD, 8'($urandom),
                          10'($urandom_range(index_end + 1, INDEX_DEPTH - 1)));
            else if (pick < 87)
                send_beat(OP_LOAD, 8'($urandom), 10'($urandom));
            else if (pick < 93)
                send_beat(OP_UNUSED, 8'($urandom), 10'($urandom), 12'($urandom),
                          12'($urandom), 16'($urandom), 16'($urandom));
            else
                send_char(8'($urandom));
        end
    endtask

    task automatic test_random_phases();
        run_phase(16, 320, 240, 70);
        run_phase(8, 4095, 4095, 70);
        run_phase(64, 4095, 4095, 70);
        run_phase(64, 64, 64, 60);
        run_phase(8, 1, 1, 40);
        run_phase(12, 100, 50, 60);
        run_phase(4 * $urandom_range(2, 16), $urandom_range(1, 4095),
                  $urandom_range(1, 4095), 70);
        run_phase(4 * $urandom_range(2, 16), $urandom_range(64, 4095),
                  $urandom_range(64, 4095), 70);
        settle();
        gaps_on = 1'b0;
        run_phase(16, 4095, 4095, 70);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_LOAD;
        m_tready     = 1'b1;
        cfg_valid    = 1'b0;
        cfg_index    = REG_FONT_SIZE;
        cfg_data     = '0;
        pen_col      = '0;
        pen_row      = '0;
        string_fore  = '0;
        string_back  = '0;
        held_lead    = '0;
        lead_waiting = 1'b0;
        string_done  = 1'b1;
        cell_size    = FONT_SIZE_RST;
        view_w       = SCREEN_W_RST;
        view_h       = SCREEN_H_RST;
        gaps_on      = 1'b1;
        err_count    = 0;
        cycles       = 0;
        beats_sent   = 0;
        beats_used   = 0;
        draws_seen   = 0;
        skips_seen   = 0;
        stops_seen   = 0;
        phases_run   = 1;
        index_end    = 0;
        for (int a = 0; a < INDEX_DEPTH; a++)
            font_index[a] = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_store_end();
        test_index_rules();
        test_screen_edges();
        test_register_writes();
        test_random_phases();

        settle();
        while (glyph_cmds_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d input beats over %0d font and screen setups.", beats_sent, phases_run);
        $display("Checked %0d draw, %0d skip and %0d edge-stop beats; %0d mismatches.",
                 draws_seen, skips_seen, stops_seen, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
